[hdl/gddn_pkg.sv]
// Constants and month tables for the Gregorian date / day number converter.
package gddn_pkg;

  localparam int unsigned DAY_W    = 5;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned YEAR_W   = 14;
  localparam int unsigned SERIAL_W = 22;
  localparam int unsigned DOY_W    = 9;
  localparam int unsigned LDAYS_W  = 12;
  localparam int unsigned Q100_W   = 8;
  localparam int unsigned PROD_W   = 2 * SERIAL_W;

  localparam logic [YEAR_W-1:0]   FIRST_YEAR    = 14'd1601;
  localparam logic [YEAR_W-1:0]   LAST_YEAR     = 14'd9999;
  localparam logic [SERIAL_W-1:0] LAST_SERIAL   = 22'd3067671;
  localparam logic [SERIAL_W-1:0] DAYS_PER_YEAR = 22'd365;
  localparam logic [YEAR_W-1:0]   CENTURY       = 14'd100;

  // floor(x / 365) = (x * RECIP_365) >> 30 for x below 2^22
  localparam logic [SERIAL_W-1:0] RECIP_365  = 22'd2941759;
  localparam int unsigned         SHIFT_365  = 30;
  // floor(x / 100) = (x * RECIP_100) >> 19 for x below 2^14
  localparam logic [SERIAL_W-1:0] RECIP_100  = 22'd5243;
  localparam int unsigned         SHIFT_100  = 19;

  localparam logic ACT_TO_SERIAL = 1'b0;
  localparam logic ACT_TO_DATE   = 1'b1;

  // Days before the start of month index idx (0 = January).
  function automatic logic [DOY_W-1:0] cum_days(input logic lp, input logic [MONTH_W-1:0] idx);
    logic [DOY_W-1:0] base;
    case (idx)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd0;
    endcase
    if (lp && idx >= 4'd2 && idx <= 4'd11) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

  // Length of month index idx (0 = January).
  function automatic logic [DAY_W-1:0] month_len(input logic lp, input logic [MONTH_W-1:0] idx);
    logic [DAY_W-1:0] len;
    case (idx)
      4'd1:                      len = lp ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

[hdl/gregorian_date_day_number_converter.sv]
// Gregorian date / serial day number converter, iterative top level.
//
// Request channel (req_valid/req_ready) carries one item: action, day_in,
// month_in, year_in and serial_in. Action 0 turns a date into a day number,
// action 1 turns a day number (1 = 1 January 1601) into a date.
// Response channel (rsp_valid/rsp_ready) returns one item per request:
// serial_out, day_out, month_out, year_out and valid_res; unused or invalid
// fields read zero.
// One shared multiplier (reciprocal division by 365 and by 100) and one adder
// path run under a small sequencer, one item at a time; req_ready is high
// only while the sequencer is idle.
// A date with year or month out of range, or a day number out of range, goes
// straight to the finishing state; a day number passes through the correction
// loop once more for each year correction after the first estimate.
// The result sits in an output register: a new request is taken while it
// waits, and the sequencer holds its finished result until the register frees.
// Reset (rst, synchronous) returns the sequencer to idle and drops rsp_valid.
module gregorian_date_day_number_converter (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_ready,
  input  logic                           action,
  input  logic [gddn_pkg::DAY_W-1:0]     day_in,
  input  logic [gddn_pkg::MONTH_W-1:0]   month_in,
  input  logic [gddn_pkg::YEAR_W-1:0]    year_in,
  input  logic [gddn_pkg::SERIAL_W-1:0]  serial_in,
  output logic                           rsp_valid,
  input  logic                           rsp_ready,
  output logic [gddn_pkg::SERIAL_W-1:0]  serial_out,
  output logic [gddn_pkg::DAY_W-1:0]     day_out,
  output logic [gddn_pkg::MONTH_W-1:0]   month_out,
  output logic [gddn_pkg::YEAR_W-1:0]    year_out,
  output logic                           valid_res
);
  import gddn_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_RECIP = 4'd1;
  localparam logic [3:0] ST_NSET  = 4'd2;
  localparam logic [3:0] ST_NMUL  = 4'd3;
  localparam logic [3:0] ST_LDAYS = 4'd4;
  localparam logic [3:0] ST_SUM   = 4'd5;
  localparam logic [3:0] ST_CHECK = 4'd6;
  localparam logic [3:0] ST_YMUL  = 4'd7;
  localparam logic [3:0] ST_LEAP  = 4'd8;
  localparam logic [3:0] ST_MONTH = 4'd9;
  localparam logic [3:0] ST_DAY   = 4'd10;
  localparam logic [3:0] ST_DONE  = 4'd11;

  logic [3:0]          state;
  logic                act;
  logic [DAY_W-1:0]    day;
  logic [MONTH_W-1:0]  month;
  logic [YEAR_W-1:0]   year;
  logic [SERIAL_W-1:0] serial;
  logic [YEAR_W-1:0]   n;
  logic [PROD_W-1:0]   prod;
  logic [LDAYS_W-1:0]  ldays;
  logic [SERIAL_W-1:0] start;
  logic [DOY_W-1:0]    doy;
  logic                leap;
  logic [MONTH_W-1:0]  mon;

  logic [SERIAL_W-1:0] res_serial;
  logic [DAY_W-1:0]    res_day;
  logic [MONTH_W-1:0]  res_month;
  logic [YEAR_W-1:0]   res_year;
  logic                res_valid;

  logic [SERIAL_W-1:0] mul_a;
  logic [SERIAL_W-1:0] mul_b;
  logic [Q100_W-1:0]   q100;
  logic [YEAR_W-1:0]   q100_x100;
  logic                hund;
  logic                leap_now;
  logic [MONTH_W-1:0]  mon_search;
  logic [DOY_W-1:0]    cum_in;
  logic [DOY_W-1:0]    cum_found;
  logic [DAY_W-1:0]    len_in;
  logic                accept;

  assign req_ready = (state == ST_IDLE);
  assign accept    = req_valid && req_ready;

  always_comb begin
    case (state)
      ST_RECIP: begin
        mul_a = serial;
        mul_b = RECIP_365;
      end
      ST_NMUL: begin
        mul_a = SERIAL_W'(n);
        mul_b = RECIP_100;
      end
      default: begin
        mul_a = SERIAL_W'(year);
        mul_b = RECIP_100;
      end
    endcase
  end

  always_comb begin
    q100      = prod[SHIFT_100 +: Q100_W];
    q100_x100 = YEAR_W'(q100) * CENTURY;
    hund      = (year == q100_x100);
    leap_now  = (year[1:0] == 2'd0 && !hund) || (hund && q100[1:0] == 2'd0);
  end

  always_comb begin
    mon_search = 4'd1;
    for (int k = 1; k < 12; k++) begin
      if (doy > cum_days(leap, MONTH_W'(k))) begin
        mon_search = mon_search + 4'd1;
      end
    end
  end

  assign cum_in    = cum_days(leap, month - 4'd1);
  assign len_in    = month_len(leap, month - 4'd1);
  assign cum_found = cum_days(leap, mon - 4'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            act        <= action;
            day        <= day_in;
            month      <= month_in;
            year       <= year_in;
            serial     <= serial_in;
            n          <= year_in - FIRST_YEAR;
            res_serial <= '0;
            res_day    <= '0;
            res_month  <= '0;
            res_year   <= '0;
            res_valid  <= 1'b0;
            if (action == ACT_TO_SERIAL) begin
              if (year_in >= FIRST_YEAR && year_in <= LAST_YEAR &&
                  month_in inside {[4'd1:4'd12]}) begin
                state <= ST_NMUL;
              end else begin
                state <= ST_DONE;
              end
            end else begin
              if (serial_in != '0 && serial_in <= LAST_SERIAL) begin
                res_valid <= 1'b1;
                state     <= ST_RECIP;
              end else begin
                state <= ST_DONE;
              end
            end
          end
        end
        ST_RECIP: begin
          prod  <= mul_a * mul_b;
          state <= ST_NSET;
        end
        ST_NSET: begin
          n     <= prod[SHIFT_365 +: YEAR_W];
          state <= ST_NMUL;
        end
        ST_NMUL: begin
          prod  <= mul_a * mul_b;
          state <= ST_LDAYS;
        end
        ST_LDAYS: begin
          ldays <= LDAYS_W'(n >> 2) - LDAYS_W'(q100) + LDAYS_W'(q100 >> 2);
          state <= ST_SUM;
        end
        ST_SUM: begin
          start <= SERIAL_W'(n) * DAYS_PER_YEAR + SERIAL_W'(ldays);
          state <= ST_CHECK;
        end
        ST_CHECK: begin
          if (act == ACT_TO_SERIAL) begin
            state <= ST_YMUL;
          end else if (start >= serial && n != '0) begin
            n     <= n - 14'd1;
            state <= ST_NMUL;
          end else begin
            year     <= FIRST_YEAR + n;
            res_year <= FIRST_YEAR + n;
            doy      <= DOY_W'(serial - start);
            state    <= ST_YMUL;
          end
        end
        ST_YMUL: begin
          prod  <= mul_a * mul_b;
          state <= ST_LEAP;
        end
        ST_LEAP: begin
          leap  <= leap_now;
          state <= ST_MONTH;
        end
        ST_MONTH: begin
          if (act == ACT_TO_SERIAL) begin
            if (day != '0 && day <= len_in) begin
              res_serial <= start + SERIAL_W'(cum_in) + SERIAL_W'(day);
              res_valid  <= 1'b1;
            end
            state <= ST_DONE;
          end else begin
            mon       <= mon_search;
            res_month <= mon_search;
            state     <= ST_DAY;
          end
        end
        ST_DAY: begin
          res_day <= DAY_W'(doy - cum_found);
          state   <= ST_DONE;
        end
        ST_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == ST_DONE && (!rsp_valid || rsp_ready)) begin
      rsp_valid  <= 1'b1;
      serial_out <= res_serial;
      day_out    <= res_day;
      month_out  <= res_month;
      year_out   <= res_year;
      valid_res  <= res_valid;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !req_ready)
    else $error("request taken while sequencer busy");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !valid_res) |->
      (serial_out == '0 && day_out == '0 && month_out == '0 && year_out == '0))
    else $error("invalid item carries non-zero fields");

  a_date_sane: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && valid_res && month_out != '0) |->
      (month_out <= 4'd12 && day_out != '0 && year_out >= FIRST_YEAR &&
       serial_out == '0))
    else $error("converted date out of range");

  a_done_moves: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && !rsp_valid) |=> (rsp_valid && state == ST_IDLE))
    else $error("finished item not moved to output register");

endmodule
